// ----- rtl/core/fet_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fet_pkg;

  // Most results one expression byte can cause.
  localparam int unsigned MAX_RES = 3;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_FIELD = 3'd0,
    KIND_OP    = 3'd1,
    KIND_VALUE = 3'd2,
    KIND_CONJ  = 3'd3,
    KIND_DONE  = 3'd4,
    KIND_ERROR = 3'd5
  } kind_t;

  // Parser phases.
  typedef enum logic [3:0] {
    PH_EXPECT  = 4'd0,
    PH_FIELD   = 4'd1,
    PH_PRE_OP  = 4'd2,
    PH_OP2     = 4'd3,
    PH_PRE_VAL = 4'd4,
    PH_BARE    = 4'd5,
    PH_QUOTE   = 4'd6,
    PH_POST    = 4'd7,
    PH_KW      = 4'd8,
    PH_ERR     = 4'd9
  } phase_t;

  // Configuration register indexes.
  localparam logic CFG_MAX_PRED   = 1'b0;
  localparam logic CFG_MAX_TOKLEN = 1'b1;

  // One result token, without its end-of-item mark.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  byte_out;
    logic [2:0]  op_code;
    logic        conj;
    logic [1:0]  error_code;
    logic [9:0]  predicate_index;
  } result_t;

  // All results caused by one input item, in order from res[0].
  typedef struct packed {
    logic [1:0]                 count;
    result_t [MAX_RES-1:0]      res;
  } group_t;

endpackage

`default_nettype wire

// ----- rtl/core/fet_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fet_parser (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [7:0]          in_ch,
  input  wire logic                in_has_char,
  input  wire logic                in_last,
  input  wire logic [10:0]         max_pred,
  input  wire logic [15:0]         max_len,
  input  wire logic                q_ready,
  output logic                     push,
  output fet_pkg::group_t          grp
);

  // Byte values the grammar looks at.
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_RBRK   = 8'h5D;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LN     = 8'h6E;
  localparam logic [7:0] CH_LD     = 8'h64;
  localparam logic [7:0] CH_LO     = 8'h6F;
  localparam logic [7:0] CH_LR     = 8'h72;

  // Held first byte of a two-byte operator.
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_BANG = 2'd1;
  localparam logic [1:0] PEND_LT   = 2'd2;
  localparam logic [1:0] PEND_GT   = 2'd3;

  // Keyword match progress.
  localparam logic [3:0] KW_IDLE  = 4'd0;
  localparam logic [3:0] KW_A     = 4'd1;
  localparam logic [3:0] KW_AN    = 4'd2;
  localparam logic [3:0] KW_AND   = 4'd3;
  localparam logic [3:0] KW_O     = 4'd4;
  localparam logic [3:0] KW_OR    = 4'd5;
  localparam logic [3:0] KW_NONE  = 4'd15;

  // Operator codes.
  localparam logic [2:0] OP_EQ    = 3'd0;
  localparam logic [2:0] OP_NE    = 3'd1;
  localparam logic [2:0] OP_CONT  = 3'd2;
  localparam logic [2:0] OP_NCONT = 3'd3;
  localparam logic [2:0] OP_LT    = 3'd4;
  localparam logic [2:0] OP_LE    = 3'd5;
  localparam logic [2:0] OP_GT    = 3'd6;
  localparam logic [2:0] OP_GE    = 3'd7;

  // Error codes.
  localparam logic [1:0] ERR_MALFORMED   = 2'd0;
  localparam logic [1:0] ERR_LIMIT       = 2'd1;
  localparam logic [1:0] ERR_FIELD_START = 2'd2;

  localparam logic [10:0] PCOUNT_MAX = 11'h7FF;

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_name_byte(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER || c == CH_DOT ||
           c == CH_LBRK || c == CH_RBRK;
  endfunction

  function automatic logic [3:0] kw_next(logic [3:0] k, logic [7:0] c);
    logic [7:0] l;
    logic [3:0] r;
    l = (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
    if (k == KW_IDLE && l == CH_LA) r = KW_A;
    else if (k == KW_A && l == CH_LN) r = KW_AN;
    else if (k == KW_AN && l == CH_LD) r = KW_AND;
    else if (k == KW_IDLE && l == CH_LO) r = KW_O;
    else if (k == KW_O && l == CH_LR) r = KW_OR;
    else r = KW_NONE;
    return r;
  endfunction

  function automatic logic [10:0] pc_inc(logic [10:0] pc);
    return (pc < PCOUNT_MAX) ? pc + 11'd1 : pc;
  endfunction

  // Appends one result to a group; a full group drops it.
  function automatic fet_pkg::group_t add_res(fet_pkg::group_t g, fet_pkg::kind_t k,
                                              logic [7:0] b, logic [2:0] op, logic cj,
                                              logic [1:0] err, logic [10:0] pc);
    fet_pkg::result_t r;
    fet_pkg::group_t  o;
    r.kind            = k;
    r.byte_out        = b;
    r.op_code         = op;
    r.conj            = cj;
    r.error_code      = err;
    r.predicate_index = pc[9:0];
    o = g;
    if (g.count != 2'(fet_pkg::MAX_RES)) begin
      o.res[g.count] = r;
      o.count        = g.count + 2'd1;
    end
    return o;
  endfunction

  // Input register.
  logic       in_valid_r;
  logic [7:0] ch_r;
  logic       has_r;
  logic       last_r;
  logic       fire;

  // Parser state.
  fet_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]      pend_r, pend_nxt;
  logic [15:0]     toklen_r, toklen_nxt;
  logic [10:0]     pcount_r, pcount_nxt;
  logic [3:0]      kw_r, kw_nxt;
  logic            esc_r, esc_nxt;
  logic            have_r, have_nxt;

  // Step work signals.
  logic            sp, fc;
  logic            grow_req;
  fet_pkg::kind_t  grow_kind;
  logic            val_req;
  logic [1:0]      p;
  fet_pkg::group_t g;

  assign fire      = in_valid_r && q_ready;
  assign in_tready = !in_valid_r || fire;
  assign push      = fire && (g.count != 2'd0);
  assign grp       = g;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ch_r   <= in_ch;
      has_r  <= in_has_char;
      last_r <= in_last;
    end
  end

  // One item: the byte step, then the end of the expression if marked.
  always_comb begin
    phase_nxt  = phase_r;
    pend_nxt   = pend_r;
    toklen_nxt = toklen_r;
    pcount_nxt = pcount_r;
    kw_nxt     = kw_r;
    esc_nxt    = esc_r;
    have_nxt   = have_r;
    g          = '0;
    sp         = is_blank(ch_r);
    fc         = is_name_byte(ch_r);
    grow_req   = 1'b0;
    grow_kind  = fet_pkg::KIND_VALUE;
    val_req    = 1'b0;
    p          = pend_r;

    if (has_r) begin
      unique case (phase_r)
        fet_pkg::PH_EXPECT: begin
          if (!sp) begin
            if (pcount_r >= max_pred) begin
              g = add_res(g, fet_pkg::KIND_ERROR, 8'd0, 3'd0, 1'b0, ERR_LIMIT, pcount_nxt);
              phase_nxt = fet_pkg::PH_ERR;
            end else if (fc) begin
              phase_nxt  = fet_pkg::PH_FIELD;
              toklen_nxt = 16'd0;
              grow_req   = 1'b1;
              grow_kind  = fet_pkg::KIND_FIELD;
            end else begin
              g = add_res(g, fet_pkg::KIND_ERROR, 8'd0, 3'd0, 1'b0, ERR_FIELD_START,
                          pcount_nxt);
              phase_nxt = fet_pkg::PH_ERR;
            end
          end
        end
        fet_pkg::PH_FIELD, fet_pkg::PH_PRE_OP: begin
          if (phase_r == fet_pkg::PH_FIELD && fc) begin
            grow_req  = 1'b1;
            grow_kind = fet_pkg::KIND_FIELD;
          end else if (sp) begin
            phase_nxt = fet_pkg::PH_PRE_OP;
          end else if (ch_r == CH_BANG) begin
            pend_nxt  = PEND_BANG;
            phase_nxt = fet_pkg::PH_OP2;
          end else if (ch_r == CH_LT) begin
            pend_nxt  = PEND_LT;
            phase_nxt = fet_pkg::PH_OP2;
          end else if (ch_r == CH_GT) begin
            pend_nxt  = PEND_GT;
            phase_nxt = fet_pkg::PH_OP2;
          end else if (ch_r == CH_EQ) begin
            g = add_res(g, fet_pkg::KIND_OP, 8'd0, OP_EQ, 1'b0, 2'd0, pcount_nxt);
            phase_nxt = fet_pkg::PH_PRE_VAL;
          end else if (ch_r == CH_TILDE) begin
            g = add_res(g, fet_pkg::KIND_OP, 8'd0, OP_CONT, 1'b0, 2'd0, pcount_nxt);
            phase_nxt = fet_pkg::PH_PRE_VAL;
          end else begin
            g = add_res(g, fet_pkg::KIND_ERROR, 8'd0, 3'd0, 1'b0, ERR_MALFORMED,
                        pcount_nxt);
            phase_nxt = fet_pkg::PH_ERR;
          end
        end
        fet_pkg::PH_OP2: begin
          pend_nxt = PEND_NONE;
          if (p == PEND_BANG) begin
            if (ch_r == CH_EQ) begin
              g = add_res(g, fet_pkg::KIND_OP, 8'd0, OP_NE, 1'b0, 2'd0, pcount_nxt);
              phase_nxt = fet_pkg::PH_PRE_VAL;
            end else if (ch_r == CH_TILDE) begin
              g = add_res(g, fet_pkg::KIND_OP, 8'd0, OP_NCONT, 1'b0, 2'd0, pcount_nxt);
              phase_nxt = fet_pkg::PH_PRE_VAL;
            end else begin
              g = add_res(g, fet_pkg::KIND_ERROR, 8'd0, 3'd0, 1'b0, ERR_MALFORMED,
                          pcount_nxt);
              phase_nxt = fet_pkg::PH_ERR;
            end
          end else begin
            phase_nxt = fet_pkg::PH_PRE_VAL;
            if (ch_r == CH_EQ) begin
              g = add_res(g, fet_pkg::KIND_OP, 8'd0, (p == PEND_GT) ? OP_GE : OP_LE,
                          1'b0, 2'd0, pcount_nxt);
            end else begin
              // The byte after a lone '<' or '>' already belongs to the value.
              g = add_res(g, fet_pkg::KIND_OP, 8'd0, (p == PEND_GT) ? OP_GT : OP_LT,
                          1'b0, 2'd0, pcount_nxt);
              val_req = 1'b1;
            end
          end
        end
        fet_pkg::PH_PRE_VAL: begin
          val_req = 1'b1;
        end
        fet_pkg::PH_BARE: begin
          if (sp) begin
            pcount_nxt = pc_inc(pcount_nxt);
            have_nxt   = 1'b1;
            phase_nxt  = fet_pkg::PH_POST;
          end else begin
            grow_req = 1'b1;
          end
        end
        fet_pkg::PH_QUOTE: begin
          if (esc_r) begin
            esc_nxt  = 1'b0;
            grow_req = 1'b1;
          end else if (ch_r == CH_BSLASH) begin
            esc_nxt = 1'b1;
          end else if (ch_r == CH_QUOTE) begin
            pcount_nxt = pc_inc(pcount_nxt);
            have_nxt   = 1'b1;
            phase_nxt  = fet_pkg::PH_POST;
          end else begin
            grow_req = 1'b1;
          end
        end
        fet_pkg::PH_POST: begin
          if (!sp) begin
            phase_nxt = fet_pkg::PH_KW;
            kw_nxt    = kw_next(KW_IDLE, ch_r);
          end
        end
        fet_pkg::PH_KW: begin
          if (sp) begin
            if (kw_r == KW_AND || kw_r == KW_OR) begin
              g = add_res(g, fet_pkg::KIND_CONJ, 8'd0, 3'd0, (kw_r == KW_OR), 2'd0,
                          pcount_nxt);
              phase_nxt = fet_pkg::PH_EXPECT;
              have_nxt  = 1'b1;
            end else begin
              g = add_res(g, fet_pkg::KIND_ERROR, 8'd0, 3'd0, 1'b0, ERR_MALFORMED,
                          pcount_nxt);
              phase_nxt = fet_pkg::PH_ERR;
            end
            kw_nxt = KW_IDLE;
          end else begin
            kw_nxt = kw_next(kw_r, ch_r);
          end
        end
        default: begin
        end
      endcase

      // Start of a value: spaces are skipped, a quote opens a quoted value.
      if (val_req && !sp) begin
        toklen_nxt = 16'd0;
        esc_nxt    = 1'b0;
        if (ch_r == CH_QUOTE) begin
          phase_nxt = fet_pkg::PH_QUOTE;
        end else begin
          phase_nxt = fet_pkg::PH_BARE;
          grow_req  = 1'b1;
        end
      end

      // A field or value byte, checked against the token length limit.
      if (grow_req) begin
        if (toklen_nxt >= max_len) begin
          g = add_res(g, fet_pkg::KIND_ERROR, 8'd0, 3'd0, 1'b0, ERR_LIMIT, pcount_nxt);
          phase_nxt = fet_pkg::PH_ERR;
        end else begin
          toklen_nxt = toklen_nxt + 16'd1;
          g = add_res(g, grow_kind, ch_r, 3'd0, 1'b0, 2'd0, pcount_nxt);
        end
      end
    end

    if (last_r) begin
      unique case (phase_nxt)
        fet_pkg::PH_EXPECT: begin
          if (have_nxt) begin
            g = add_res(g, fet_pkg::KIND_ERROR, 8'd0, 3'd0, 1'b0, ERR_MALFORMED,
                        pcount_nxt);
          end else begin
            g = add_res(g, fet_pkg::KIND_DONE, 8'd0, 3'd0, 1'b0, 2'd0, pcount_nxt);
          end
        end
        fet_pkg::PH_OP2: begin
          if (pend_nxt != PEND_BANG) begin
            g = add_res(g, fet_pkg::KIND_OP, 8'd0, (pend_nxt == PEND_GT) ? OP_GT : OP_LT,
                        1'b0, 2'd0, pcount_nxt);
          end
          g = add_res(g, fet_pkg::KIND_ERROR, 8'd0, 3'd0, 1'b0, ERR_MALFORMED, pcount_nxt);
        end
        fet_pkg::PH_BARE: begin
          pcount_nxt = pc_inc(pcount_nxt);
          g = add_res(g, fet_pkg::KIND_DONE, 8'd0, 3'd0, 1'b0, 2'd0, pcount_nxt);
        end
        fet_pkg::PH_QUOTE: begin
          // A trailing backslash is sent as a value byte before the error, unless the token is at its length limit.
          if (esc_nxt && toklen_nxt >= max_len) begin
            g = add_res(g, fet_pkg::KIND_ERROR, 8'd0, 3'd0, 1'b0, ERR_LIMIT, pcount_nxt);
          end else begin
            if (esc_nxt) begin
              g = add_res(g, fet_pkg::KIND_VALUE, CH_BSLASH, 3'd0, 1'b0, 2'd0,
                          pcount_nxt);
            end
            g = add_res(g, fet_pkg::KIND_ERROR, 8'd0, 3'd0, 1'b0, ERR_MALFORMED,
                        pcount_nxt);
          end
        end
        fet_pkg::PH_POST: begin
          g = add_res(g, fet_pkg::KIND_DONE, 8'd0, 3'd0, 1'b0, 2'd0, pcount_nxt);
        end
        fet_pkg::PH_KW: begin
          // A conjunction at the end is sent, then the expression is malformed.
          if (kw_nxt == KW_AND || kw_nxt == KW_OR) begin
            g = add_res(g, fet_pkg::KIND_CONJ, 8'd0, 3'd0, (kw_nxt == KW_OR), 2'd0,
                        pcount_nxt);
          end
          g = add_res(g, fet_pkg::KIND_ERROR, 8'd0, 3'd0, 1'b0, ERR_MALFORMED, pcount_nxt);
        end
        fet_pkg::PH_ERR: begin
        end
        default: begin
          g = add_res(g, fet_pkg::KIND_ERROR, 8'd0, 3'd0, 1'b0, ERR_MALFORMED, pcount_nxt);
        end
      endcase

      // Every expression end restarts the parser.
      phase_nxt  = fet_pkg::PH_EXPECT;
      pend_nxt   = PEND_NONE;
      toklen_nxt = 16'd0;
      pcount_nxt = 11'd0;
      kw_nxt     = KW_IDLE;
      esc_nxt    = 1'b0;
      have_nxt   = 1'b0;
    end
  end

  // Parser state advances once per processed item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= fet_pkg::PH_EXPECT;
      pend_r   <= PEND_NONE;
      toklen_r <= 16'd0;
      pcount_r <= 11'd0;
      kw_r     <= KW_IDLE;
      esc_r    <= 1'b0;
      have_r   <= 1'b0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      pend_r   <= pend_nxt;
      toklen_r <= toklen_nxt;
      pcount_r <= pcount_nxt;
      kw_r     <= kw_nxt;
      esc_r    <= esc_nxt;
      have_r   <= have_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/fet_outq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fet_outq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire fet_pkg::group_t  grp,
  output logic                  q_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output fet_pkg::result_t      out_res,
  output logic                  out_last
);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  fet_pkg::group_t   mem_r [QDEPTH];
  logic [QAW-1:0]    head_r, tail_r;
  logic [QAW:0]      cnt_r;
  logic [1:0]        idx_r;
  fet_pkg::group_t   hg;
  logic              take, pop;

  assign q_ready   = (cnt_r != (QAW+1)'(QDEPTH));
  assign out_valid = (cnt_r != '0);
  assign hg        = mem_r[head_r];
  assign out_last  = (idx_r == hg.count - 2'd1);
  assign take      = out_valid && out_ready;
  assign pop       = take && out_last;

  // Pick the current result of the head group.
  always_comb begin
    unique case (idx_r)
      2'd0:    out_res = hg.res[0];
      2'd1:    out_res = hg.res[1];
      default: out_res = hg.res[2];
    endcase
  end

  // Group storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[tail_r] <= grp;
    end
  end

  // Pointers, fill count and position within the head group.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
      idx_r  <= 2'd0;
    end else begin
      if (push) begin
        tail_r <= tail_r + QAW'(1);
      end
      if (pop) begin
        head_r <= head_r + QAW'(1);
      end
      if (take) begin
        idx_r <= out_last ? 2'd0 : idx_r + 2'd1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (QAW+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (QAW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/filter_expression_tokenizer_core.sv -----
// An accepted byte is held in the input register; its results are then written into the queue.
// Throughput: one byte per cycle; results leave one per cycle, while out_tready is high, from
//   a four-group queue, and input stalls only while that queue is full.
// Reset (rst_n low, synchronous): the parser returns to awaiting the first predicate, the
//   queue empties, and the limits return to 256 predicates and 4096 bytes per token.
`timescale 1ns / 1ps
`default_nettype none

module filter_expression_tokenizer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] ch
  input  wire logic        in_tuser,   // [0] has_char
  input  wire logic        in_tlast,   // end of the expression
  // Result stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [2:0] kind, [10:3] byte_out, [13:11] op_code,
                                       // [14] conj, [16:15] error_code,
                                       // [26:17] predicate_index, [31:27] zero
  output logic             out_tlast,  // last result of the input item
  // Configuration writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [10:0]       max_pred_r;
  logic [15:0]       max_len_r;
  logic              q_ready;
  logic              push;
  fet_pkg::group_t   grp;
  fet_pkg::result_t  res;

  // Limit registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_pred_r <= 11'd256;
      max_len_r  <= 16'd4096;
    end else if (cfg_valid) begin
      if (cfg_index == fet_pkg::CFG_MAX_PRED) begin
        max_pred_r <= cfg_data[10:0];
      end else if (cfg_index == fet_pkg::CFG_MAX_TOKLEN) begin
        max_len_r <= cfg_data;
      end
    end
  end

  // Grammar checker and token generator.
  fet_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_ch       (in_tdata),
    .in_has_char (in_tuser),
    .in_last     (in_tlast),
    .max_pred    (max_pred_r),
    .max_len     (max_len_r),
    .q_ready     (q_ready),
    .push        (push),
    .grp         (grp)
  );

  // Result queue and serializer.
  fet_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .grp       (grp),
    .q_ready   (q_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res),
    .out_last  (out_tlast)
  );

  assign out_tdata = {5'd0, res.predicate_index, res.error_code, res.conj, res.op_code,
                      res.byte_out, res.kind};

  // Input only stalls while results are waiting in a full queue.
  a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

  // Done and error results always end their item.
  a_end_kinds_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] == fet_pkg::KIND_DONE ||
                   out_tdata[2:0] == fet_pkg::KIND_ERROR) |-> out_tlast)
    else $error("done or error result not last of its item");

  // A done result carries no byte, operator, conjunction or error code.
  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == fet_pkg::KIND_DONE |-> out_tdata[16:3] == 14'd0)
    else $error("done result carries token fields");

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  // Error codes carried in error results.
  localparam logic [1:0] ERR_MALFORMED   = 2'd0;
  localparam logic [1:0] ERR_LIMIT       = 2'd1;
  localparam logic [1:0] ERR_FIELD_START = 2'd2;

  // Comparison operator codes.
  localparam logic [2:0] OP_EQ        = 3'd0;
  localparam logic [2:0] OP_NE        = 3'd1;
  localparam logic [2:0] OP_CONTAINS  = 3'd2;
  localparam logic [2:0] OP_NCONTAINS = 3'd3;
  localparam logic [2:0] OP_LT        = 3'd4;
  localparam logic [2:0] OP_GT        = 3'd6;

  // Conjunction kinds.
  localparam logic CONJ_AND = 1'b0;
  localparam logic CONJ_OR  = 1'b1;

  // First byte of a two-byte operator that is waiting for its second byte.
  localparam logic [1:0] HELD_NONE = 2'd0;
  localparam logic [1:0] HELD_BANG = 2'd1;
  localparam logic [1:0] HELD_LT   = 2'd2;
  localparam logic [1:0] HELD_GT   = 2'd3;

  // Keyword match progress.
  localparam logic [3:0] KW_IDLE  = 4'd0;
  localparam logic [3:0] KW_A     = 4'd1;
  localparam logic [3:0] KW_AN    = 4'd2;
  localparam logic [3:0] KW_AND   = 4'd3;
  localparam logic [3:0] KW_O     = 4'd4;
  localparam logic [3:0] KW_OR    = 4'd5;
  localparam logic [3:0] KW_NONE  = 4'd15;

  // Bytes with a meaning of their own.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  localparam int IDLE_LIMIT    = 4000;
  localparam int RANDOM_ITEMS  = 370;
  localparam int ITEMS_PER_SET = 55;
  localparam int NUM_SETS      = 7;

  // One token as the block should report it.
  typedef struct packed {
    fet_pkg::kind_t kind;
    logic [7:0]     b;
    logic [2:0]     op;
    logic           cj;
    logic [1:0]     err;
    logic [9:0]     pidx;
    logic           lst;
  } token_t;

  // Tracks the tokenizer state, predicts tokens and checks the result stream.
  class token_scoreboard;
    int unsigned     max_preds;
    int unsigned     max_toklen;
    fet_pkg::phase_t ph;
    logic [1:0]      held_op;
    int unsigned     tok_len;
    int unsigned     pred_cnt;
    logic [3:0]      kw;
    bit              esc;
    bit              have_pred;
    bit              conj_kind;
    token_t          expected_tokens[$];
    token_t          item_tokens[$];
    int              mismatches;
    int              checked;

    function new();
      max_preds = 256;
      max_toklen = 4096;
      mismatches = 0;
      checked = 0;
      clear_parse();
    endfunction

    static function bit is_blank(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    static function bit is_name_byte(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") ||
             c == "_" || c == "." || c == "[" || c == "]";
    endfunction

    function void clear_parse();
      ph = fet_pkg::PH_EXPECT;
      held_op = HELD_NONE;
      tok_len = 0;
      pred_cnt = 0;
      kw = KW_IDLE;
      esc = 0;
      have_pred = 0;
      conj_kind = CONJ_AND;
    endfunction

    function void set_limit(logic idx, logic [15:0] val);
      if (idx == fet_pkg::CFG_MAX_PRED) begin
        max_preds = 32'(val[10:0]);
      end else begin
        max_toklen = 32'(val);
      end
    endfunction

    function int outstanding();
      return expected_tokens.size();
    endfunction

    function void push_token(fet_pkg::kind_t k, logic [7:0] b, logic [2:0] op, logic cj,
                             logic [1:0] err);
      token_t t;
      if (item_tokens.size() >= fet_pkg::MAX_RES) return;
      t.kind = k;
      t.b = b;
      t.op = op;
      t.cj = cj;
      t.err = err;
      t.pidx = pred_cnt[9:0];
      t.lst = 1'b0;
      item_tokens.insert(item_tokens.size(), t);
    endfunction

    function void raise_error(logic [1:0] code);
      push_token(fet_pkg::KIND_ERROR, 8'h00, 3'd0, 1'b0, code);
      ph = fet_pkg::PH_ERR;
    endfunction

    // A field or value byte, refused once the token is at its length limit.
    function void grow(fet_pkg::kind_t k, logic [7:0] c);
      if (tok_len >= max_toklen) begin
        raise_error(ERR_LIMIT);
      end else begin
        tok_len++;
        push_token(k, c, 3'd0, 1'b0, 2'd0);
      end
    endfunction

    function void close_predicate();
      if (pred_cnt < 11'h7FF) pred_cnt++;
      have_pred = 1;
      ph = fet_pkg::PH_POST;
    endfunction

    function void begin_value(logic [7:0] c);
      if (is_blank(c)) return;
      tok_len = 0;
      esc = 0;
      if (c == CH_QUOTE) begin
        ph = fet_pkg::PH_QUOTE;
      end else begin
        ph = fet_pkg::PH_BARE;
        grow(fet_pkg::KIND_VALUE, c);
      end
    endfunction

    function void take_op(logic [7:0] c);
      if (c == CH_BANG) begin
        held_op = HELD_BANG;
        ph = fet_pkg::PH_OP2;
      end else if (c == CH_LT) begin
        held_op = HELD_LT;
        ph = fet_pkg::PH_OP2;
      end else if (c == CH_GT) begin
        held_op = HELD_GT;
        ph = fet_pkg::PH_OP2;
      end else if (c == CH_EQ) begin
        push_token(fet_pkg::KIND_OP, 8'h00, OP_EQ, 1'b0, 2'd0);
        ph = fet_pkg::PH_PRE_VAL;
      end else if (c == CH_TILDE) begin
        push_token(fet_pkg::KIND_OP, 8'h00, OP_CONTAINS, 1'b0, 2'd0);
        ph = fet_pkg::PH_PRE_VAL;
      end else begin
        raise_error(ERR_MALFORMED);
      end
    endfunction

    function logic [3:0] next_kw(logic [3:0] k, logic [7:0] c);
      logic [7:0] l;
      l = (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
      if (k == KW_IDLE && l == "a") return KW_A;
      if (k == KW_A && l == "n") return KW_AN;
      if (k == KW_AN && l == "d") return KW_AND;
      if (k == KW_IDLE && l == "o") return KW_O;
      if (k == KW_O && l == "r") return KW_OR;
      return KW_NONE;
    endfunction

    function void close_keyword();
      if (kw == KW_AND || kw == KW_OR) begin
        conj_kind = (kw == KW_OR) ? CONJ_OR : CONJ_AND;
        push_token(fet_pkg::KIND_CONJ, 8'h00, 3'd0, conj_kind, 2'd0);
        ph = fet_pkg::PH_EXPECT;
        have_pred = 1;
      end else begin
        raise_error(ERR_MALFORMED);
      end
      kw = KW_IDLE;
    endfunction

    function void consume_byte(logic [7:0] c);
      logic [1:0] held;
      logic [2:0] base;
      case (ph)
        fet_pkg::PH_EXPECT: if (!is_blank(c)) begin
          if (pred_cnt >= max_preds) begin
            raise_error(ERR_LIMIT);
          end else if (is_name_byte(c)) begin
            ph = fet_pkg::PH_FIELD;
            tok_len = 0;
            grow(fet_pkg::KIND_FIELD, c);
          end else begin
            raise_error(ERR_FIELD_START);
          end
        end
        fet_pkg::PH_FIELD: begin
          if (is_name_byte(c)) grow(fet_pkg::KIND_FIELD, c);
          else if (is_blank(c)) ph = fet_pkg::PH_PRE_OP;
          else take_op(c);
        end
        fet_pkg::PH_PRE_OP: if (!is_blank(c)) take_op(c);
        fet_pkg::PH_OP2: begin
          held = held_op;
          held_op = HELD_NONE;
          if (held == HELD_BANG) begin
            if (c == CH_EQ) begin
              push_token(fet_pkg::KIND_OP, 8'h00, OP_NE, 1'b0, 2'd0);
              ph = fet_pkg::PH_PRE_VAL;
            end else if (c == CH_TILDE) begin
              push_token(fet_pkg::KIND_OP, 8'h00, OP_NCONTAINS, 1'b0, 2'd0);
              ph = fet_pkg::PH_PRE_VAL;
            end else begin
              raise_error(ERR_MALFORMED);
            end
          end else begin
            // A '<' or '>' not followed by '=' leaves this byte to start the value.
            base = (held == HELD_GT) ? OP_GT : OP_LT;
            ph = fet_pkg::PH_PRE_VAL;
            if (c == CH_EQ) begin
              push_token(fet_pkg::KIND_OP, 8'h00, base + 3'd1, 1'b0, 2'd0);
            end else begin
              push_token(fet_pkg::KIND_OP, 8'h00, base, 1'b0, 2'd0);
              begin_value(c);
            end
          end
        end
        fet_pkg::PH_PRE_VAL: begin_value(c);
        fet_pkg::PH_BARE: begin
          if (is_blank(c)) close_predicate();
          else grow(fet_pkg::KIND_VALUE, c);
        end
        fet_pkg::PH_QUOTE: begin
          if (esc) begin
            esc = 0;
            grow(fet_pkg::KIND_VALUE, c);
          end else if (c == CH_BSLASH) begin
            esc = 1;
          end else if (c == CH_QUOTE) begin
            close_predicate();
          end else begin
            grow(fet_pkg::KIND_VALUE, c);
          end
        end
        fet_pkg::PH_POST: if (!is_blank(c)) begin
          ph = fet_pkg::PH_KW;
          kw = next_kw(KW_IDLE, c);
        end
        fet_pkg::PH_KW: begin
          if (is_blank(c)) close_keyword();
          else kw = next_kw(kw, c);
        end
        default: ;
      endcase
    endfunction

    function void close_expression();
      case (ph)
        fet_pkg::PH_EXPECT: begin
          if (have_pred) raise_error(ERR_MALFORMED);
          else push_token(fet_pkg::KIND_DONE, 8'h00, 3'd0, 1'b0, 2'd0);
        end
        fet_pkg::PH_OP2: begin
          if (held_op != HELD_BANG) begin
            push_token(fet_pkg::KIND_OP, 8'h00, (held_op == HELD_GT) ? OP_GT : OP_LT,
                       1'b0, 2'd0);
          end
          raise_error(ERR_MALFORMED);
        end
        fet_pkg::PH_BARE: begin
          close_predicate();
          push_token(fet_pkg::KIND_DONE, 8'h00, 3'd0, 1'b0, 2'd0);
        end
        fet_pkg::PH_QUOTE: begin
          // A dangling backslash still counts as a value byte.
          if (esc) begin
            esc = 0;
            grow(fet_pkg::KIND_VALUE, CH_BSLASH);
          end
          if (ph != fet_pkg::PH_ERR) raise_error(ERR_MALFORMED);
        end
        fet_pkg::PH_POST: push_token(fet_pkg::KIND_DONE, 8'h00, 3'd0, 1'b0, 2'd0);
        fet_pkg::PH_KW: begin
          close_keyword();
          if (ph != fet_pkg::PH_ERR) raise_error(ERR_MALFORMED);
        end
        fet_pkg::PH_ERR: ;
        default: raise_error(ERR_MALFORMED);
      endcase
      clear_parse();
    endfunction

    // Called for every accepted input transaction.
    function void note_item(logic [7:0] c, logic has_char, logic lst);
      item_tokens.delete();
      if (has_char) consume_byte(c);
      if (lst) close_expression();
      if (item_tokens.size() > 0) item_tokens[item_tokens.size() - 1].lst = 1'b1;
      foreach (item_tokens[i]) expected_tokens.insert(expected_tokens.size(), item_tokens[i]);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 40) $display("testbench: MISMATCH %s", msg);
    endtask

    // Called for every accepted result transaction.
    task check_token(logic [31:0] d, logic lst);
      token_t w;
      checked++;
      if (expected_tokens.size() == 0) begin
        report_mismatch($sformatf("token %0d arrived with nothing expected: data %h last %b",
                                  checked, d, lst));
        return;
      end
      w = expected_tokens.pop_front();
      if (d[2:0] !== w.kind || d[10:3] !== w.b || d[13:11] !== w.op || d[14] !== w.cj ||
          d[16:15] !== w.err || d[26:17] !== w.pidx || d[31:27] !== 5'd0 || lst !== w.lst) begin
        report_mismatch($sformatf(
          "token %0d: got kind %0d byte %h op %0d conj %0d err %0d pred %0d pad %h last %b, %s",
          checked, d[2:0], d[10:3], d[13:11], d[14], d[16:15], d[26:17], d[31:27], lst,
          $sformatf("wanted kind %0d byte %h op %0d conj %0d err %0d pred %0d last %b",
                    w.kind, w.b, w.op, w.cj, w.err, w.pidx, w.lst)));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = 16'h0000;

  token_scoreboard sb;
  bit          in_took = 0;
  bit          cfg_took = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  bit          steady = 0;
  int          items_sent = 0;
  int          rand_bytes = 0;
  int          expressions = 0;
  int          limit_sets = 0;
  int          rx_cycle = 0;
  logic [7:0]  expr_q[$];

  filter_expression_tokenizer_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample all three channels at the rising edge.
  always @(posedge clk) begin
    in_took = in_tvalid && in_tready;
    cfg_took = cfg_valid && cfg_ready;
    if (in_took) sb.note_item(in_tdata, in_tuser, in_tlast);
    if (cfg_took) sb.set_limit(cfg_index, cfg_data);
    if (out_tvalid && out_tready) sb.check_token(out_tdata, out_tlast);
    if (in_took || cfg_took || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles = idle_cycles + 1;
  end

  // The receiver cycles through open, coin-flip, comb and sparse stall patterns.
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_COMB, RX_SPARSE} rx_mode_t;

  always @(negedge clk) begin
    rx_cycle++;
    case (rx_mode_t'((rx_cycle / 150) % 4))
      RX_OPEN:  out_tready = 1'b1;
      RX_COIN:  out_tready = 1'($urandom_range(1, 0));
      RX_COMB:  out_tready = (rx_cycle % 9) < 3;
      default:  out_tready = ($urandom_range(3, 0) == 0);
    endcase
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    @(posedge clk);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("testbench: no transaction for %0d cycles", IDLE_LIMIT);
    $display("testbench: done, errors");
    $finish;
  end

  // Offer one input transaction; called at a falling edge, returns at one.
  task automatic send_item(input logic [7:0] c, input logic has_char, input logic lst);
    if (!steady && burst_left == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
      burst_left = $urandom_range(20, 1);
    end
    if (burst_left > 0) burst_left--;
    in_tvalid = 1'b1;
    in_tdata = c;
    in_tuser = has_char;
    in_tlast = lst;
    @(negedge clk);
    while (!in_took) @(negedge clk);
    items_sent++;
  endtask

  // Hold the input until every predicted token has come out.
  task automatic drain();
    in_tvalid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_limits(input logic [15:0] preds, input logic [15:0] toklen);
    cfg_valid = 1'b1;
    cfg_index = fet_pkg::CFG_MAX_PRED;
    cfg_data = preds;
    @(negedge clk);
    while (!cfg_took) @(negedge clk);
    cfg_index = fet_pkg::CFG_MAX_TOKLEN;
    cfg_data = toklen;
    @(negedge clk);
    while (!cfg_took) @(negedge clk);
    cfg_valid = 1'b0;
    limit_sets++;
  endtask

  task automatic send_expression();
    bit split_end;
    split_end = (expr_q.size() == 0) || ($urandom_range(4, 0) == 0);
    foreach (expr_q[i]) begin
      // Now and then an empty item that must do nothing.
      if ($urandom_range(29, 0) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(expr_q[i], 1'b1, !split_end && i == expr_q.size() - 1);
    end
    if (split_end) send_item(8'($urandom), 1'b0, 1'b1);
    expressions++;
  endtask

  task automatic send_text(input string s, input bit ends);
    for (int i = 0; i < s.len(); i++) begin
      send_item(s[i], 1'b1, ends && i == s.len() - 1);
    end
  endtask

  // Appends one byte to the expression being built.
  function automatic void queue_byte(logic [7:0] c);
    expr_q.insert(expr_q.size(), c);
  endfunction

  function automatic logic [7:0] pick_space();
    return ($urandom_range(2, 0) != 0) ? 8'h20 : 8'($urandom_range(8'h0D, 8'h09));
  endfunction

  function automatic void add_spaces(int lo, int hi);
    repeat ($urandom_range(hi, lo)) queue_byte(pick_space());
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endfunction

  function automatic void add_field(int maxlen);
    string set;
    set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_.[]";
    repeat ($urandom_range(maxlen, 1)) queue_byte(set[$urandom_range(set.len() - 1, 0)]);
  endfunction

  function automatic void add_op();
    string ops[8];
    ops = '{"=", "!=", "~", "!~", "<", "<=", ">", ">="};
    push_text(ops[$urandom_range(7, 0)]);
  endfunction

  function automatic void add_value();
    int n;
    logic [7:0] c;
    if ($urandom_range(2, 0) == 0) begin
      // Quoted value: any bytes, backslash escapes included.
      queue_byte(CH_QUOTE);
      n = $urandom_range(4, 0);
      repeat (n) begin
        if ($urandom_range(4, 0) == 0) begin
          queue_byte(CH_BSLASH);
          queue_byte(8'($urandom));
        end else begin
          do c = 8'($urandom); while (c == CH_QUOTE || c == CH_BSLASH);
          queue_byte(c);
        end
      end
      queue_byte(CH_QUOTE);
    end else begin
      n = $urandom_range(4, 1);
      for (int i = 0; i < n; i++) begin
        do c = 8'($urandom);
        while (token_scoreboard::is_blank(c) || (i == 0 && c == CH_QUOTE));
        queue_byte(c);
      end
    end
  endfunction

  function automatic void add_conj();
    string w;
    logic [7:0] c;
    add_spaces(1, 2);
    w = ($urandom_range(1, 0) != 0) ? "and" : "or";
    for (int i = 0; i < w.len(); i++) begin
      c = w[i];
      if ($urandom_range(1, 0) != 0) c = c & 8'hDF;
      queue_byte(c);
    end
    add_spaces(1, 2);
  endfunction

  // Mostly well-formed expressions with random content, plus broken ones and noise.
  function automatic void build_expression();
    int npred;
    int cut;
    int pick;
    string tails[8];
    tails = '{"and", "OR", "An", "xor", "o", "orr", "andd", "Or "};
    expr_q.delete();
    npred = ($urandom_range(7, 0) == 0) ? $urandom_range(6, 4) : $urandom_range(3, 1);
    for (int i = 0; i < npred; i++) begin
      if (i > 0) add_conj();
      else add_spaces(0, 1);
      add_field(5);
      add_spaces(0, 2);
      add_op();
      add_spaces(0, 2);
      add_value();
    end
    add_spaces(0, 1);
    pick = $urandom_range(11, 0);
    if (pick == 8) begin
      cut = $urandom_range(expr_q.size() - 1, 0);
      while (expr_q.size() > cut) void'(expr_q.pop_back());
    end else if (pick == 9) begin
      // Dangling or misspelled conjunction, sometimes with a half predicate.
      queue_byte(8'h20);
      push_text(tails[$urandom_range(7, 0)]);
      if ($urandom_range(1, 0) != 0) begin
        add_spaces(1, 1);
        add_field(3);
        if ($urandom_range(1, 0) != 0) add_op();
      end
    end else if (pick == 10) begin
      expr_q[$urandom_range(expr_q.size() - 1, 0)] = 8'($urandom);
    end else if (pick == 11) begin
      expr_q.delete();
      repeat ($urandom_range(8, 1)) queue_byte(8'($urandom));
    end
  endfunction

  initial begin
    int pred_tab[NUM_SETS];
    int tok_tab[NUM_SETS];
    int set_items;
    pred_tab = '{256, 1, 2, 1024, 2047, 3, 5};
    tok_tab = '{4096, 65535, 3, 1, 2, 5, 4096};
    sb = new();
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty expression, escape at end, pending '>', bad field start,
    // lone '!', lookahead on '<', empty item, mixed-case AND, field at end.
    send_item(8'h00, 1'b0, 1'b1);
    send_text("x!~\"\\", 1);
    send_text("y>", 1);
    send_text("!", 1);
    send_text("a!b", 1);
    send_text("a<b\t", 0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_text("AnD c", 1);

    // Random expressions under a series of limit settings.
    for (int s = 0; rand_bytes < RANDOM_ITEMS; s++) begin
      if (s > 0) begin
        drain();
        write_limits(16'(pred_tab[s % NUM_SETS]), 16'(tok_tab[s % NUM_SETS]));
      end
      steady = (s % 3 == 2);
      set_items = 0;
      while (set_items < ITEMS_PER_SET) begin
        build_expression();
        set_items += expr_q.size() + 1;
        rand_bytes += expr_q.size() + 1;
        send_expression();
      end
    end

    in_tvalid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    if (sb.outstanding() != 0) sb.report_mismatch("tokens still expected at the end");

    $display("testbench: %0d expressions in %0d input items, %0d tokens checked",
             expressions, items_sent, sb.checked);
    $display("testbench: %0d limit settings written, %0d mismatches",
             limit_sets, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
